### rtl/core/csp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csp_pkg
// Types, widths and constants shared by the cosine similarity core.
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam int COMPONENTS = 5;
  localparam int COMP_W     = 7;
  localparam int PCT_W      = 7;
  localparam int PCT_MAX    = 100;

  // lane products and sums
  localparam int LPROD_W = 2 * COMP_W;
  localparam int SUM_W   = LPROD_W + $clog2(COMPONENTS);
  localparam int MAG_W   = 2 * SUM_W;

  // 200 * dot, and its square
  localparam int SCALE   = 200;
  localparam int SCALE_W = 8;
  localparam int DSC_W   = SUM_W + SCALE_W;
  localparam int RHS_W   = 2 * DSC_W;

  // (2n-1)^2 table and the search product
  localparam int KSQ_W   = 2 * (PCT_W + 1);
  localparam int KSQ_N   = 2 ** PCT_W;
  localparam int TEST_W  = KSQ_W + MAG_W;

  typedef struct packed {
    logic [COMP_W-1:0] a_comp0;
    logic [COMP_W-1:0] a_comp1;
    logic [COMP_W-1:0] a_comp2;
    logic [COMP_W-1:0] a_comp3;
    logic [COMP_W-1:0] a_comp4;
    logic [COMP_W-1:0] b_comp0;
    logic [COMP_W-1:0] b_comp1;
    logic [COMP_W-1:0] b_comp2;
    logic [COMP_W-1:0] b_comp3;
    logic [COMP_W-1:0] b_comp4;
  } item_t;

  typedef struct packed {
    logic [PCT_W-1:0] similarity_pct;
    logic             zero_vector;
  } result_t;

  typedef struct packed {
    logic [LPROD_W-1:0] ab;
    logic [LPROD_W-1:0] aa;
    logic [LPROD_W-1:0] bb;
  } lane_t;

  // state carried down the search pipeline
  typedef struct packed {
    logic [PCT_W-1:0] n;
    logic [MAG_W-1:0] prod;
    logic [RHS_W-1:0] rhs;
    logic             zero;
  } srch_t;

  typedef logic [KSQ_W-1:0] ksq_arr_t [KSQ_N];

  function automatic ksq_arr_t build_ksq();
    ksq_arr_t t;
    int k;
    for (int c = 0; c < KSQ_N; c++) begin
      k = (c == 0) ? 1 : 2 * c - 1;
      t[c] = KSQ_W'(k * k);
    end
    return t;
  endfunction

  // KSQ[c] = (2c-1)^2, entry zero unused
  localparam ksq_arr_t KSQ = build_ksq();

endpackage
`default_nettype wire

### rtl/core/csp_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csp_lane
// One component lane: registers a*b, a*a and b*b.
// ----------------------------------------------------------------------------
module csp_lane (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [csp_pkg::COMP_W-1:0] a,
  input  wire logic [csp_pkg::COMP_W-1:0] b,
  output csp_pkg::lane_t                  prods
);

  always_ff @(posedge clk) begin
    if (en) begin
      prods.ab <= csp_pkg::LPROD_W'(a) * csp_pkg::LPROD_W'(b);
      prods.aa <= csp_pkg::LPROD_W'(a) * csp_pkg::LPROD_W'(a);
      prods.bb <= csp_pkg::LPROD_W'(b) * csp_pkg::LPROD_W'(b);
    end
  end

endmodule
`default_nettype wire

### rtl/core/csp_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csp_merge
// Sums the lane products, then forms magA*magB and (200*dot)^2.
// Three stages, each stalls only when it holds data the next cannot take.
// ----------------------------------------------------------------------------
module csp_merge (
  input  wire logic           clk,
  input  wire logic           rst,
  input  csp_pkg::lane_t      lanes [csp_pkg::COMPONENTS],
  input  wire logic           valid_in,
  input  wire logic           down_en,
  output logic                up_en,
  output logic                valid_out,
  output csp_pkg::srch_t      dout
);

  logic                        v1, v2, v3;
  logic                        e1, e2, e3;
  logic [csp_pkg::SUM_W-1:0]   dot_sum, ma_sum, mb_sum;
  logic [csp_pkg::SUM_W-1:0]   dot, ma, mb;
  logic                        zero1, zero2;
  logic [csp_pkg::MAG_W-1:0]   prod2;
  logic [csp_pkg::DSC_W-1:0]   dsc2;

  assign e3    = !v3 || down_en;
  assign e2    = !v2 || e3;
  assign e1    = !v1 || e2;
  assign up_en = e1;
  assign valid_out = v3;

  always_comb begin
    dot_sum = '0;
    ma_sum  = '0;
    mb_sum  = '0;
    for (int i = 0; i < csp_pkg::COMPONENTS; i++) begin
      dot_sum = dot_sum + csp_pkg::SUM_W'(lanes[i].ab);
      ma_sum  = ma_sum  + csp_pkg::SUM_W'(lanes[i].aa);
      mb_sum  = mb_sum  + csp_pkg::SUM_W'(lanes[i].bb);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (e1) v1 <= valid_in;
      if (e2) v2 <= v1;
      if (e3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (e1) begin
      dot   <= dot_sum;
      ma    <= ma_sum;
      mb    <= mb_sum;
      zero1 <= (ma_sum == '0) || (mb_sum == '0);
    end
    if (e2) begin
      prod2 <= csp_pkg::MAG_W'(ma) * csp_pkg::MAG_W'(mb);
      dsc2  <= csp_pkg::DSC_W'(dot) * csp_pkg::DSC_W'(csp_pkg::SCALE);
      zero2 <= zero1;
    end
    if (e3) begin
      dout.n    <= '0;
      dout.prod <= prod2;
      dout.rhs  <= csp_pkg::RHS_W'(dsc2) * csp_pkg::RHS_W'(dsc2);
      dout.zero <= zero2;
    end
  end

endmodule
`default_nettype wire

### rtl/core/csp_search_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csp_search_stage
// One bit of the binary search for the largest n with
// (2n-1)^2 * magA*magB <= (200*dot)^2 and n <= 100.
// ----------------------------------------------------------------------------
module csp_search_stage (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [csp_pkg::PCT_W-1:0] trial_bit,
  input  wire logic                      valid_in,
  input  csp_pkg::srch_t                 din,
  input  wire logic                      down_en,
  output logic                           up_en,
  output logic                           valid_out,
  output csp_pkg::srch_t                 dout
);

  logic [csp_pkg::PCT_W-1:0]  cand;
  logic [csp_pkg::KSQ_W-1:0]  ksq;
  logic [csp_pkg::TEST_W-1:0] lhs;
  logic                       pass;

  assign up_en = !valid_out || down_en;

  assign cand = din.n | trial_bit;
  assign ksq  = csp_pkg::KSQ[cand];
  assign lhs  = csp_pkg::TEST_W'(ksq) * csp_pkg::TEST_W'(din.prod);
  // the test is monotone in n, so keeping the bit on a pass converges
  assign pass = (cand <= csp_pkg::PCT_W'(csp_pkg::PCT_MAX)) &&
                (lhs <= csp_pkg::TEST_W'(din.rhs));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (up_en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (up_en) begin
      dout.n    <= pass ? cand : din.n;
      dout.prod <= din.prod;
      dout.rhs  <= din.rhs;
      dout.zero <= din.zero;
    end
  end

endmodule
`default_nettype wire

### rtl/core/cosine_similarity_percent_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cosine_similarity_percent_core
// Cosine similarity of two five-component score vectors, as a percentage.
// ----------------------------------------------------------------------------
// Takes one vector pair per cycle while the result side does not stall and
// returns round-half-up(100*cos) through one lane stage of per-component
// multipliers, three merge stages (sums, magA*magB and 200*dot, then the
// square of 200*dot), and seven search stages that settle one bit of the
// result each with a 16 x 34 multiply and compare. Every stage holds its data
// only while the stage after it is full, so bubbles collapse and an item can
// be taken while a finished result waits. A pair where either vector is all zero
// returns 0 with zero_vector set.
module cosine_similarity_percent_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_ready,
  input  csp_pkg::item_t  item,
  output logic            result_valid,
  input  wire logic       result_ready,
  output csp_pkg::result_t result
);

  localparam int SRCH_STAGES = csp_pkg::PCT_W;

  logic [csp_pkg::COMP_W-1:0] a_v [csp_pkg::COMPONENTS];
  logic [csp_pkg::COMP_W-1:0] b_v [csp_pkg::COMPONENTS];
  csp_pkg::lane_t             lanes [csp_pkg::COMPONENTS];
  logic                       lane_valid;
  logic                       lane_en;
  logic                       merge_en;
  logic                       merge_valid;
  csp_pkg::srch_t             merge_out;

  logic                       s_valid [SRCH_STAGES+1];
  csp_pkg::srch_t             s_data  [SRCH_STAGES+1];
  logic                       s_en    [SRCH_STAGES+1];

  assign a_v[0] = item.a_comp0;
  assign a_v[1] = item.a_comp1;
  assign a_v[2] = item.a_comp2;
  assign a_v[3] = item.a_comp3;
  assign a_v[4] = item.a_comp4;
  assign b_v[0] = item.b_comp0;
  assign b_v[1] = item.b_comp1;
  assign b_v[2] = item.b_comp2;
  assign b_v[3] = item.b_comp3;
  assign b_v[4] = item.b_comp4;

  assign lane_en    = !lane_valid || merge_en;
  assign item_ready = lane_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid <= 1'b0;
    end else if (lane_en) begin
      lane_valid <= item_valid;
    end
  end

  for (genvar i = 0; i < csp_pkg::COMPONENTS; i++) begin : g_lane
    csp_lane u_lane (
      .clk   (clk),
      .en    (lane_en),
      .a     (a_v[i]),
      .b     (b_v[i]),
      .prods (lanes[i])
    );
  end

  csp_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .lanes     (lanes),
    .valid_in  (lane_valid),
    .down_en   (s_en[0]),
    .up_en     (merge_en),
    .valid_out (merge_valid),
    .dout      (merge_out)
  );

  assign s_valid[0] = merge_valid;
  assign s_data[0]  = merge_out;

  // most significant result bit first
  for (genvar j = 0; j < SRCH_STAGES; j++) begin : g_srch
    localparam logic [csp_pkg::PCT_W-1:0] TRIAL =
      csp_pkg::PCT_W'(1) << (SRCH_STAGES - 1 - j);
    csp_search_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .trial_bit (TRIAL),
      .valid_in  (s_valid[j]),
      .din       (s_data[j]),
      .down_en   (s_en[j+1]),
      .up_en     (s_en[j]),
      .valid_out (s_valid[j+1]),
      .dout      (s_data[j+1])
    );
  end

  assign s_en[SRCH_STAGES]     = result_ready;
  assign result_valid          = s_valid[SRCH_STAGES];
  assign result.similarity_pct = s_data[SRCH_STAGES].zero ? '0 : s_data[SRCH_STAGES].n;
  assign result.zero_vector    = s_data[SRCH_STAGES].zero;

`ifndef SYNTHESIS
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.similarity_pct <= csp_pkg::PCT_W'(csp_pkg::PCT_MAX))
    else $error("similarity_pct above 100");

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid && !result_ready)
    else $error("input stalled while the output is free");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !result_valid)
    else $error("result valid right after reset");
`endif

endmodule
`default_nettype wire

### tb/cosine_similarity_percent_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cosine_similarity_percent_core_tb
// Self-checking bench for the cosine similarity core. A short directed table
// covers zero vectors, parallel and orthogonal pairs and exact half-percent
// ties. A long random run follows, with random idle bursts on both sides.
// Every result is compared in order against the table's expected value or an exact integer predictor.
// ----------------------------------------------------------------------------
module cosine_similarity_percent_core_tb;

  localparam int PRED         = -1;    // expected value left to the predictor
  localparam int PLAN_ROWS    = 19;
  localparam int PLAN_COLS    = 2 * csp_pkg::COMPONENTS + 2;
  localparam int RANDOM_PAIRS = 1680;
  localparam int CALM_PAIRS   = 200;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 24;
  localparam int REPORT_MAX   = 10;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_ready;
  csp_pkg::item_t   item = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  csp_pkg::result_t result;

  csp_pkg::result_t similarity_q[$];   // expected results, oldest first
  csp_pkg::result_t item_want = '0;    // expectation for the pair now on the bus
  bit      calm = 1'b0;       // no idling on either side
  int      errors = 0;
  int      idle_cycles = 0;
  int      ready_hold = 0;

  // a0..a4, b0..b4, expected pct, expected zero flag
  int plan [PLAN_ROWS][PLAN_COLS] = '{
    '{  0,  0,  0,  0,  0,    0,  0,  0,  0,  0,     0, 1},
    '{  0,  0,  0,  0,  0,  127,127,127,127,127,     0, 1},
    '{127,127,127,127,127,    0,  0,  0,  0,  0,     0, 1},
    '{  0,  0,  0,  0,  1,    0,  0,  0,  0,  0,     0, 1},
    '{127,127,127,127,127,  127,127,127,127,127,   100, 0},
    '{  1,  0,  0,  0,  0,    1,  0,  0,  0,  0,   100, 0},
    '{  0,  0,  0,  0,127,    0,  0,  0,  0,  1,   100, 0},
    '{  1,  1,  1,  1,  1,  127,127,127,127,127,   100, 0},
    '{ 85, 85, 85, 85, 85,   42, 42, 42, 42, 42,   100, 0},
    '{127,  0,  0,  0,  0,    0,127,  0,  0,  0,     0, 0},  // orthogonal
    '{  0,127,  0,127,  0,  127,  0,127,  0,127,     0, 0},
    '{  1,  0,  0,  0,  0,    1,  7,  3,  2,  1,    13, 0},  // exactly 12.5
    '{  1,  0,  0,  0,  0,    3,  7,  2,  1,  1,    38, 0},  // exactly 37.5
    '{127,127,127,127,127,  127,  0,  0,  0,  0,  PRED, 0},
    '{  1,  2,  4,  8, 16,   64, 32, 16,  8,  4,  PRED, 0},
    '{ 64, 32, 16,  8,  4,    1,  2,  4,  8, 16,  PRED, 0},
    '{127,  0,  0,  0,  1,    0,  1,127,127,127,  PRED, 0},
    '{  1,  0,  0,  0,  0,    1,127,127,127,127,  PRED, 0},
    '{126,  1,  0,  0,  0,    1,126,  0,  0,  0,  PRED, 0}
  };

  cosine_similarity_percent_core u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // largest n with (2n-1)^2 * magA * magB <= (200 * dot)^2, capped at 100
  function automatic csp_pkg::result_t similarity_of(input csp_pkg::item_t p);
    logic [csp_pkg::COMP_W-1:0] a [csp_pkg::COMPONENTS];
    logic [csp_pkg::COMP_W-1:0] b [csp_pkg::COMPONENTS];
    logic [csp_pkg::SUM_W-1:0]  dot, mag_a, mag_b;
    logic [csp_pkg::MAG_W-1:0]  mag_prod;
    logic [csp_pkg::DSC_W-1:0]  dot_sc;
    logic [csp_pkg::RHS_W-1:0]  dot_sq;
    logic [csp_pkg::TEST_W-1:0] lhs;
    logic [csp_pkg::PCT_W:0]    odd;
    csp_pkg::result_t           r;
    a = '{p.a_comp0, p.a_comp1, p.a_comp2, p.a_comp3, p.a_comp4};
    b = '{p.b_comp0, p.b_comp1, p.b_comp2, p.b_comp3, p.b_comp4};
    dot   = '0;
    mag_a = '0;
    mag_b = '0;
    for (int i = 0; i < csp_pkg::COMPONENTS; i++) begin
      dot   = dot + a[i] * b[i];
      mag_a = mag_a + a[i] * a[i];
      mag_b = mag_b + b[i] * b[i];
    end
    r = '0;
    if (mag_a == 0 || mag_b == 0) begin
      r.zero_vector = 1'b1;
      return r;
    end
    mag_prod = mag_a * mag_b;
    dot_sc   = csp_pkg::DSC_W'(dot) * csp_pkg::DSC_W'(csp_pkg::SCALE);
    dot_sq   = dot_sc * dot_sc;
    for (int n = 1; n <= csp_pkg::PCT_MAX; n++) begin
      odd = (csp_pkg::PCT_W+1)'(2 * n - 1);
      lhs = odd * odd * mag_prod;
      if (lhs > dot_sq) break;
      r.similarity_pct = csp_pkg::PCT_W'(n);
    end
    return r;
  endfunction

  function automatic csp_pkg::item_t pack_pair(input int v [2*csp_pkg::COMPONENTS]);
    logic [2*csp_pkg::COMPONENTS*csp_pkg::COMP_W-1:0] flat;
    for (int j = 0; j < 2 * csp_pkg::COMPONENTS; j++)
      flat[(2*csp_pkg::COMPONENTS-1-j)*csp_pkg::COMP_W +: csp_pkg::COMP_W] =
        csp_pkg::COMP_W'(v[j]);
    return csp_pkg::item_t'(flat);
  endfunction

  function automatic csp_pkg::item_t draw_pair();
    int v [2*csp_pkg::COMPONENTS];
    int mode;
    mode = $urandom_range(0, 99);
    for (int j = 0; j < 2 * csp_pkg::COMPONENTS; j++) begin
      v[j] = $urandom_range(0, 127);
      if (mode >= 80) begin
        v[j] = v[j] % 4;   // tiny values: many exact ratios and ties
      end else if (mode >= 65) begin
        case ($urandom_range(0, 3))
          0: v[j] = 0;
          1: v[j] = 127;
          2: v[j] = 1;
          default: ;
        endcase
      end else if (mode >= 50 && $urandom_range(0, 1) == 1) begin
        v[j] = 0;
      end
    end
    // nearly parallel pairs land close to 100
    if (mode >= 30 && mode < 50) begin
      for (int j = 0; j < csp_pkg::COMPONENTS; j++) begin
        if (mode < 38) begin
          v[csp_pkg::COMPONENTS+j] = v[j] >> 1;
        end else begin
          v[csp_pkg::COMPONENTS+j] = v[j] + int'($urandom_range(0, 6)) - 3;
          if (v[csp_pkg::COMPONENTS+j] < 0) v[csp_pkg::COMPONENTS+j] = 0;
          if (v[csp_pkg::COMPONENTS+j] > 127) v[csp_pkg::COMPONENTS+j] = 127;
        end
      end
    end
    if (mode >= 95) begin
      case ($urandom_range(0, 2))
        0: for (int j = 0; j < csp_pkg::COMPONENTS; j++) v[j] = 0;
        1: for (int j = 0; j < csp_pkg::COMPONENTS; j++) v[csp_pkg::COMPONENTS+j] = 0;
        default: for (int j = 0; j < 2 * csp_pkg::COMPONENTS; j++) v[j] = 0;
      endcase
    end
    return pack_pair(v);
  endfunction

  task automatic log_miss(input bit has_want, input csp_pkg::result_t want,
                          input csp_pkg::result_t got);
    errors++;
    if (errors <= REPORT_MAX) begin
      if (has_want)
        $display("%0t: mismatch: expected pct=%0d zero=%0b, got pct=%0d zero=%0b",
                 $time, want.similarity_pct, want.zero_vector,
                 got.similarity_pct, got.zero_vector);
      else
        $display("%0t: unexpected result: pct=%0d zero=%0b",
                 $time, got.similarity_pct, got.zero_vector);
    end
  endtask

  // present one pair and hold it until the transfer
  task automatic push_pair(input csp_pkg::item_t p, input csp_pkg::result_t want);
    int gap;
    gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       <= p;
    item_want   = want;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    item_valid <= 1'b0;
    do @(negedge clk); while (similarity_q.size() != 0);
  endtask

  // result side: random stall bursts unless calm
  always @(negedge clk) begin
    if (calm) begin
      result_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else if ($urandom_range(0, 3) != 0) begin
      result_ready <= 1'b1;
      ready_hold = $urandom_range(0, 15);
    end else begin
      result_ready <= 1'b0;
      ready_hold = $urandom_range(0, 11);
    end
  end

  // check results first, then queue the pair taken at this edge
  always @(posedge clk) begin
    csp_pkg::result_t want;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (similarity_q.size() == 0) begin
          log_miss(1'b0, '0, result);
        end else begin
          want = similarity_q.pop_front();
          if (result.similarity_pct !== want.similarity_pct ||
              result.zero_vector !== want.zero_vector)
            log_miss(1'b1, want, result);
        end
      end
      if (item_valid && item_ready) similarity_q.insert(similarity_q.size(), item_want);
      if ((item_valid && item_ready) || (result_valid && result_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  initial begin
    int               vals [2*csp_pkg::COMPONENTS];
    csp_pkg::item_t   p;
    csp_pkg::result_t want;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < PLAN_ROWS; r++) begin
      for (int j = 0; j < 2 * csp_pkg::COMPONENTS; j++) vals[j] = plan[r][j];
      p = pack_pair(vals);
      if (plan[r][2*csp_pkg::COMPONENTS] == PRED) begin
        want = similarity_of(p);
      end else begin
        want.similarity_pct = csp_pkg::PCT_W'(plan[r][2*csp_pkg::COMPONENTS]);
        want.zero_vector    = plan[r][2*csp_pkg::COMPONENTS+1][0];
      end
      push_pair(p, want);
    end
    wait_for_results();

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i == RANDOM_PAIRS / 2) wait_for_results();
      if (i == RANDOM_PAIRS - CALM_PAIRS) calm <= 1'b1;
      p = draw_pair();
      push_pair(p, similarity_of(p));
    end
    wait_for_results();
    repeat (TAIL_CYCLES) @(negedge clk);

    if (errors == 0 && similarity_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

### sim.f
rtl/core/csp_pkg.sv
rtl/core/csp_lane.sv
rtl/core/csp_merge.sv
rtl/core/csp_search_stage.sv
rtl/core/cosine_similarity_percent_core.sv
tb/cosine_similarity_percent_core_tb.sv
